### rtl/rbd_pkg.sv
package rbd_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int VAL_W   = 32;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;
  localparam int START_W = 4;
  localparam int START_CNT = 1 << START_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Register index, taken from paddr[2].
  localparam logic REG_START_INDEX = 1'b0;

  typedef struct packed {
    logic take;    // accept the request and update pointers
    logic finish;  // capture slot read data into the result
  } rbd_cmd_t;

  typedef struct packed {
    logic read_needed;  // offered request is a pop that will succeed
  } rbd_stat_t;

endpackage

### rtl/rbd_ctrl.sv
module rbd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rbd_pkg::rbd_stat_t dp_stat,
  output rbd_pkg::rbd_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // Result register is free when empty or being taken this cycle.
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == ST_IDLE) && out_free);
  assign cmd.take   = in_valid && !in_stall;
  assign cmd.finish = (state_r == ST_READ);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.take && dp_stat.read_needed) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((cmd.take && !dp_stat.read_needed) || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/rbd_datapath.sv
module rbd_datapath #(
  parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rbd_pkg::rbd_cmd_t                  cmd,
  output rbd_pkg::rbd_stat_t                 dp_stat,
  input  logic [rbd_pkg::ACT_W-1:0]          in_action,
  input  logic signed [rbd_pkg::VAL_W-1:0]   in_push_value,
  output logic signed [rbd_pkg::VAL_W-1:0]   out_pop_value,
  output logic [rbd_pkg::STAT_W-1:0]         out_status,
  output logic [rbd_pkg::FILL_W-1:0]         out_fill_count,
  input  logic                               start_we,
  input  logic [rbd_pkg::START_W-1:0]        start_wdata,
  output logic [rbd_pkg::START_W-1:0]        start_index
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [rbd_pkg::VAL_W-1:0] mem [DEPTH];
  logic [rbd_pkg::VAL_W-1:0] rd_data_r;

  logic [AW-1:0] home_tbl [rbd_pkg::START_CNT];
  logic [AW-1:0] front_r, front_nxt, back_r, back_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [rbd_pkg::START_W-1:0] start_r;

  logic [rbd_pkg::VAL_W-1:0] pop_value_r;
  logic [rbd_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [rbd_pkg::FILL_W-1:0] fill_r;

  logic [AW-1:0] home, eff_front, eff_back;
  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en, rd_en;
  logic          is_empty, is_full;

  // Start index modulo depth, folded at elaboration.
  for (genvar i = 0; i < rbd_pkg::START_CNT; i++) begin : g_home
    assign home_tbl[i] = AW'(i % DEPTH);
  end

  assign home      = home_tbl[start_r];
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(DEPTH));
  // Positions snap back to home whenever nothing is held.
  assign eff_front = is_empty ? home : front_r;
  assign eff_back  = is_empty ? home : back_r;

  assign front_inc = (eff_front == AW'(DEPTH - 1)) ? '0 : eff_front + AW'(1);
  assign back_inc  = (eff_back == AW'(DEPTH - 1)) ? '0 : eff_back + AW'(1);
  assign front_dec = (eff_front == '0) ? AW'(DEPTH - 1) : eff_front - AW'(1);
  assign back_dec  = (eff_back == '0) ? AW'(DEPTH - 1) : eff_back - AW'(1);

  always_comb begin
    front_nxt  = eff_front;
    back_nxt   = eff_back;
    count_nxt  = count_r;
    status_nxt = rbd_pkg::STAT_OK;
    wr_en      = 1'b0;
    wr_addr    = eff_back;
    rd_en      = 1'b0;
    rd_addr    = eff_front;
    dp_stat.read_needed = 1'b0;
    case (in_action)
      rbd_pkg::ACT_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = rbd_pkg::STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = eff_back;
          back_nxt  = back_inc;
          count_nxt = count_r + CW'(1);
        end
      end
      rbd_pkg::ACT_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = rbd_pkg::STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = front_dec;
          front_nxt = front_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      rbd_pkg::ACT_POP_BACK: begin
        if (is_empty) begin
          status_nxt = rbd_pkg::STAT_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = back_dec;
          back_nxt  = back_dec;
          count_nxt = count_r - CW'(1);
          dp_stat.read_needed = 1'b1;
        end
      end
      rbd_pkg::ACT_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = rbd_pkg::STAT_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = eff_front;
          front_nxt = front_inc;
          count_nxt = count_r - CW'(1);
          dp_stat.read_needed = 1'b1;
        end
      end
      default: begin
        status_nxt = rbd_pkg::STAT_OK;
      end
    endcase
  end

  // Slot store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) mem[wr_addr] <= in_push_value;
    if (cmd.take && rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      start_r <= '0;
    end else begin
      if (cmd.take) count_r <= count_nxt;
      if (start_we) start_r <= start_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      status_r    <= status_nxt;
      fill_r      <= rbd_pkg::FILL_W'(count_nxt);
      pop_value_r <= '0;
    end else if (cmd.finish) begin
      pop_value_r <= rd_data_r;
    end
  end

  assign out_pop_value  = pop_value_r;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;
  assign start_index    = start_r;

endmodule

### rtl/ring_buffer_deque_unit.sv
// Result timing: a push or a refused request has its result registered in the
//   cycle after acceptance; a successful pop first registers the slot read.
// Throughput: one request per cycle for pushes and refusals while not stalled;
//   a pop blocks until its result loads; the next request may enter as one drains.
// Reset: synchronous, active low; clears the fill count, start index, FSM and
//   output valid. The slot store is not cleared and needs no clearing pass.
module ring_buffer_deque_unit #(
  parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rbd_pkg::ACT_W-1:0]          in_action,
  input  logic signed [rbd_pkg::VAL_W-1:0]   in_push_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rbd_pkg::VAL_W-1:0]   out_pop_value,
  output logic [rbd_pkg::STAT_W-1:0]         out_status,
  output logic [rbd_pkg::FILL_W-1:0]         out_fill_count,
  // APB-style configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rbd_pkg::APB_AW-1:0]         paddr,
  input  logic [rbd_pkg::APB_DW-1:0]         pwdata,
  output logic [rbd_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  rbd_pkg::rbd_cmd_t  cmd;
  rbd_pkg::rbd_stat_t dp_stat;

  logic                        start_we;
  logic [rbd_pkg::START_W-1:0] start_index;

  // Register index lives in paddr[2]; low byte-offset bits are ignored.
  // Only the start index register exists; writes elsewhere are dropped.
  assign pready   = 1'b1;
  assign start_we = psel && penable && pwrite &&
                    (paddr[2] == rbd_pkg::REG_START_INDEX);

  // Read back the start index; other addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == rbd_pkg::REG_START_INDEX) begin
      prdata = rbd_pkg::APB_DW'(start_index);
    end
  end

  // Controller: accepts a request, waits out the slot read on a pop and
  // holds the result valid until the consumer takes it.
  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  // Datapath: slot store, front/back positions, fill count and the
  // result payload registers.
  rbd_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .dp_stat        (dp_stat),
    .in_action      (in_action),
    .in_push_value  (in_push_value),
    .out_pop_value  (out_pop_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .start_we       (start_we),
    .start_wdata    (pwdata[rbd_pkg::START_W-1:0]),
    .start_index    (start_index)
  );

`ifndef SYNTHESIS
  // A slot read always lands in the result register on the next edge.
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("pop result not loaded after slot read");

  // A held result must block new requests.
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("request accepted while result register is stalled");

  // A successful pop shows no result until its read data arrives.
  a_pop_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && dp_stat.read_needed) |=> (!out_valid && in_stall))
    else $error("pop result presented before slot read completed");
`endif

endmodule
